FILE: rtl/core/arpc_pkg.sv
package arpc_pkg;

   // cache geometry
   localparam int SLOTS      = 16;
   localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W      = $clog2(SLOTS + 1);
   localparam int MIN_LENGTH = 28;

   // arp opcodes
   localparam logic [15:0] OP_REQUEST = 16'd1;
   localparam logic [15:0] OP_REPLY   = 16'd2;

   // result status codes
   localparam logic [2:0] ST_HIT     = 3'd0;
   localparam logic [2:0] ST_MISS    = 3'd1;
   localparam logic [2:0] ST_LEARNED = 3'd2;
   localparam logic [2:0] ST_FOR_US  = 3'd3;
   localparam logic [2:0] ST_IGNORED = 3'd4;

   // request kinds
   localparam logic REQ_RESOLVE = 1'b0;
   localparam logic REQ_PACKET  = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [31:0] lookup_address;
      logic [15:0] packet_length;
      logic [15:0] arp_opcode;
      logic [31:0] sender_address;
      logic [47:0] sender_hw;
      logic [31:0] target_address;
   } arpc_request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [47:0] resolved_hw;
   } arpc_response_type;

   // one stored cache entry
   typedef struct packed {
      logic [31:0] address;
      logic [47:0] hw;
   } arpc_entry_type;

endpackage

FILE: rtl/core/arp_address_cache_unit.sv
// sequence: resolves and replies scan the entries one per cycle through one comparator,
//   stopping early on a match; packets that need no search skip the scan; every
//   result waits in the finishing state while the output is held by back-pressure
// flow: one item at a time, the next is taken once the result is registered
// reset: synchronous, clears all entry valid bits, the local address and the control

module arp_address_cache_unit
   import arpc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  arpc_request_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output arpc_response_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [CNT_W-1:0]  CNT_END   = CNT_W'(SLOTS);

   logic [1:0]              state_ff, state_in;
   arpc_request_type        req_ff, req_in;
   logic [31:0]             local_address_ff, local_address_in;
   logic [SLOTS-1:0]        slot_valid_ff, slot_valid_in;
   logic [CNT_W-1:0]        issue_cnt_ff, issue_cnt_in;
   logic [SLOT_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       hit_idx_ff, hit_idx_in;
   logic                    free_found_ff, free_found_in;
   logic [SLOT_W-1:0]       free_idx_ff, free_idx_in;
   logic [47:0]             hit_hw_ff, hit_hw_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   arpc_response_type       rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    out_free;
   logic                    is_learn;
   logic [31:0]             key;
   logic                    ram_we;
   logic [SLOT_W-1:0]       ram_wr_addr;
   arpc_entry_type          ram_wr_data;
   logic [SLOT_W-1:0]       ram_rd_addr;
   arpc_entry_type          ram_rd_data;
   logic                    entry_match;
   logic                    long_enough;

   // entry store: address and mac side by side
   arpc_ram #(
      .WIDTH ($bits(arpc_entry_type)),
      .DEPTH (SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_ready   = (state_ff == S_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign is_learn    = (req_ff.req_type == REQ_PACKET)
                        && (req_ff.packet_length >= 16'(MIN_LENGTH))
                        && (req_ff.arp_opcode == OP_REPLY);
   assign key         = is_learn ? req_ff.sender_address : req_ff.lookup_address;
   assign long_enough = (req_data.packet_length >= 16'(MIN_LENGTH));
   assign ram_rd_addr = issue_cnt_ff[SLOT_W-1:0];
   assign entry_match = cmp_vld_ff && slot_valid_ff[cmp_idx_ff]
                        && (ram_rd_data.address == key);

   // learn write target: matching entry, else lowest free, else entry zero
   always_comb begin
      ram_wr_data.address = req_ff.sender_address;
      ram_wr_data.hw      = req_ff.sender_hw;
      if (found_ff) begin
         ram_wr_addr = hit_idx_ff;
      end else if (free_found_ff) begin
         ram_wr_addr = free_idx_ff;
      end else begin
         ram_wr_addr = '0;
      end
      ram_we = (state_ff == S_DONE) && out_free && is_learn;
   end

   // sequencer
   always_comb begin
      state_in         = state_ff;
      req_in           = req_ff;
      local_address_in = local_address_ff;
      slot_valid_in    = slot_valid_ff;
      issue_cnt_in     = issue_cnt_ff;
      cmp_idx_in       = cmp_idx_ff;
      cmp_vld_in       = 1'b0;
      found_in         = found_ff;
      hit_idx_in       = hit_idx_ff;
      free_found_in    = free_found_ff;
      free_idx_in      = free_idx_ff;
      hit_hw_in        = hit_hw_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_data_in      = rsp_data_ff;

      if (csr_wr_en) begin
         local_address_in = csr_wr_data;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_in        = req_data;
               issue_cnt_in  = '0;
               found_in      = 1'b0;
               free_found_in = 1'b0;
               hit_hw_in     = '0;
               if (req_data.req_type == REQ_RESOLVE) begin
                  state_in = S_SCAN;
               end else if (long_enough && req_data.arp_opcode == OP_REPLY) begin
                  state_in = S_SCAN;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // issue one entry read per cycle
            if (issue_cnt_ff != CNT_END) begin
               issue_cnt_in = issue_cnt_ff + CNT_W'(1);
               cmp_idx_in   = issue_cnt_ff[SLOT_W-1:0];
               cmp_vld_in   = 1'b1;
            end
            // compare the entry read last cycle
            if (cmp_vld_ff) begin
               if (entry_match) begin
                  found_in   = 1'b1;
                  hit_idx_in = cmp_idx_ff;
                  hit_hw_in  = ram_rd_data.hw;
                  cmp_vld_in = 1'b0;
                  state_in   = S_DONE;
               end else begin
                  if (!slot_valid_ff[cmp_idx_ff] && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = cmp_idx_ff;
                  end
                  if (cmp_idx_ff == LAST_SLOT) begin
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.resolved_hw = '0;
               if (req_ff.req_type == REQ_RESOLVE) begin
                  rsp_data_in.status      = found_ff ? ST_HIT : ST_MISS;
                  rsp_data_in.resolved_hw = found_ff ? hit_hw_ff : 48'd0;
               end else if (req_ff.packet_length < 16'(MIN_LENGTH)) begin
                  rsp_data_in.status = ST_IGNORED;
               end else if (req_ff.arp_opcode == OP_REPLY) begin
                  rsp_data_in.status         = ST_LEARNED;
                  slot_valid_in[ram_wr_addr] = 1'b1;
               end else if (req_ff.arp_opcode == OP_REQUEST
                            && req_ff.target_address == local_address_ff) begin
                  rsp_data_in.status = ST_FOR_US;
               end else begin
                  rsp_data_in.status = ST_IGNORED;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         local_address_ff <= '0;
         slot_valid_ff    <= '0;
         cmp_vld_ff       <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         local_address_ff <= local_address_in;
         slot_valid_ff    <= slot_valid_in;
         cmp_vld_ff       <= cmp_vld_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload and scan registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      issue_cnt_ff  <= issue_cnt_in;
      cmp_idx_ff    <= cmp_idx_in;
      found_ff      <= found_in;
      hit_idx_ff    <= hit_idx_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      hit_hw_ff     <= hit_hw_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result beat only follows the finishing state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result appeared without finishing a request");

   // only hits carry a mac
   a_hw_zero_on_non_hit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.status != ST_HIT |-> rsp_data_ff.resolved_hw == 48'd0)
      else $error("non-hit result carries a mac");

   // entries are written only when a reply finishes
   a_write_on_learn: assert property (@(posedge clock) disable iff (reset)
      ram_we |=> rsp_valid_ff && rsp_data_ff.status == ST_LEARNED)
      else $error("entry written without a learned result");

   // the compare pipeline only runs while scanning
   a_cmp_in_scan: assert property (@(posedge clock) disable iff (reset)
      cmp_vld_ff |-> state_ff == S_SCAN)
      else $error("compare active outside the scan");

endmodule

FILE: rtl/core/arpc_ram.sv
module arpc_ram
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
)
(
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: tb/arp_cache_scoreboard.sv
`timescale 1ns / 100ps

package arp_cache_tb_pkg;
   import arpc_pkg::*;

   // mirror of the address cache plus the queue of answers still owed
   class arp_cache_scoreboard;
      bit                entry_live[SLOTS];
      bit [31:0]         entry_ip[SLOTS];
      bit [47:0]         entry_mac[SLOTS];
      bit [31:0]         host_address;
      arpc_response_type expected_answers[$];
      int                mismatches;
      int                status_seen[5];

      function new();
         host_address = '0;
         mismatches   = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      // lowest live entry holding ip, -1 when absent
      function int find_entry(bit [31:0] ip);
         for (int i = 0; i < SLOTS; i++) begin
            if (entry_live[i] && entry_ip[i] == ip) return i;
         end
         return -1;
      endfunction

      // same address first, then lowest free entry, then entry 0 when full
      function void store_mapping(bit [31:0] ip, bit [47:0] mac);
         int idx;
         idx = find_entry(ip);
         if (idx < 0) begin
            idx = 0;
            for (int i = SLOTS - 1; i >= 0; i--) begin
               if (!entry_live[i]) idx = i;
            end
         end
         entry_ip[idx]   = ip;
         entry_mac[idx]  = mac;
         entry_live[idx] = 1'b1;
      endfunction

      // work out the answer to an accepted request beat
      function void note_request(arpc_request_type r);
         arpc_response_type ans;
         int idx;
         ans.status      = ST_IGNORED;
         ans.resolved_hw = '0;
         if (r.req_type == REQ_RESOLVE) begin
            idx = find_entry(r.lookup_address);
            if (idx >= 0) begin
               ans.status      = ST_HIT;
               ans.resolved_hw = entry_mac[idx];
            end else begin
               ans.status = ST_MISS;
            end
         end else if (r.packet_length >= MIN_LENGTH) begin
            if (r.arp_opcode == OP_REPLY) begin
               store_mapping(r.sender_address, r.sender_hw);
               ans.status = ST_LEARNED;
            end else if (r.arp_opcode == OP_REQUEST
                         && r.target_address == host_address) begin
               ans.status = ST_FOR_US;
            end
         end
         status_seen[ans.status]++;
         expected_answers.push_back(ans);
      endfunction

      // compare a response beat with the oldest owed answer
      function void check_response(arpc_response_type got);
         arpc_response_type want;
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response, status %0d hw %h", $time, got.status,
                     got.resolved_hw);
            mismatches++;
            return;
         end
         want = expected_answers.pop_front();
         if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            mismatches++;
         end
         if (got.resolved_hw !== want.resolved_hw) begin
            $display("%0t: resolved_hw expected %h actual %h", $time, want.resolved_hw,
                     got.resolved_hw);
            mismatches++;
         end
      endfunction
   endclass

endpackage

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import arpc_pkg::*;
   import arp_cache_tb_pkg::*;

   localparam int IP_POOL       = 24;
   localparam int PHASE_ITEMS   = 650;
   localparam int SETTLE_CYCLES = SLOTS + 8;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   arpc_request_type  req_data    = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   arpc_response_type rsp_data;
   logic              csr_wr_en   = 1'b0;
   logic [31:0]       csr_wr_data = '0;

   arp_cache_scoreboard book;
   int                  sender_idle_pct   = 0;
   int                  receiver_idle_pct = 0;
   logic [31:0]         known_ips[IP_POOL];
   logic [31:0]         phase_ip[3];

   arp_address_cache_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // watchdog
   initial begin
      #4_000_000;
      $display("Some tests failed");
      $finish;
   end

   // beat monitor and receiver back-pressure
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) book.check_response(rsp_data);
         if (req_valid && req_ready) book.note_request(req_data);
      end
      rsp_ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // every field random, callers override what matters
   function automatic arpc_request_type scrambled_request();
      arpc_request_type r;
      r.req_type       = 1'($urandom);
      r.lookup_address = $urandom;
      r.packet_length  = 16'($urandom);
      r.arp_opcode     = 16'($urandom);
      r.sender_address = $urandom;
      r.sender_hw      = {16'($urandom), 32'($urandom)};
      r.target_address = $urandom;
      return r;
   endfunction

   function automatic arpc_request_type make_lookup(logic [31:0] ip);
      arpc_request_type r;
      r                = scrambled_request();
      r.req_type       = REQ_RESOLVE;
      r.lookup_address = ip;
      return r;
   endfunction

   function automatic arpc_request_type make_packet(logic [15:0] len, logic [15:0] op,
                                                    logic [31:0] sip, logic [47:0] smac,
                                                    logic [31:0] tip);
      arpc_request_type r;
      r                = scrambled_request();
      r.req_type       = REQ_PACKET;
      r.packet_length  = len;
      r.arp_opcode     = op;
      r.sender_address = sip;
      r.sender_hw      = smac;
      r.target_address = tip;
      return r;
   endfunction

   // mostly lookups and replies over a pool wider than the cache, some noise
   function automatic arpc_request_type random_request();
      arpc_request_type r;
      int pick;
      r    = scrambled_request();
      pick = $urandom_range(99);
      if (pick < 40) begin
         r.req_type = REQ_RESOLVE;
         if ($urandom_range(3) != 0) r.lookup_address = known_ips[$urandom_range(IP_POOL - 1)];
      end else if (pick < 85) begin
         r.req_type      = REQ_PACKET;
         r.packet_length = 16'($urandom_range(1500, MIN_LENGTH));
         if (pick < 70) begin
            r.arp_opcode = OP_REPLY;
            if ($urandom_range(9) != 0)
               r.sender_address = known_ips[$urandom_range(IP_POOL - 1)];
         end else begin
            r.arp_opcode = OP_REQUEST;
            if ($urandom_range(9) < 6) r.target_address = book.host_address;
            else if ($urandom_range(1) != 0)
               r.target_address = known_ips[$urandom_range(IP_POOL - 1)];
         end
      end else begin
         // short packets, stray opcodes, anything at all
         r.req_type = REQ_PACKET;
         case ($urandom_range(2))
            0: begin
               r.packet_length  = 16'($urandom_range(MIN_LENGTH - 1));
               r.arp_opcode     = $urandom_range(1) ? OP_REQUEST : OP_REPLY;
               r.target_address = book.host_address;
            end
            1: begin
               r.arp_opcode = 16'($urandom_range(3));
            end
            default: begin
            end
         endcase
      end
      return r;
   endfunction

   // drive one request beat and wait for it to be taken
   task automatic send_request(input arpc_request_type r);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   // let every owed answer come back, then a little settle time
   task automatic drain();
      req_valid <= 1'b0;
      while (book.expected_answers.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_host_address(input logic [31:0] ip);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= ip;
      @(posedge clock);
      book.host_address = ip;
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      book = new();
      known_ips[0] = 32'h0000_0000;
      known_ips[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < IP_POOL; i++) known_ips[i] = $urandom;
      phase_ip[0] = 32'hFFFF_FFFF;
      phase_ip[1] = $urandom;
      phase_ip[2] = 32'h0000_0000;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty cache, local address still zero
      send_request(make_lookup(32'h0000_0000));
      send_request(make_lookup(32'hFFFF_FFFF));
      send_request(make_packet(16'd28, OP_REQUEST, $urandom, 48'h0, 32'h0000_0000));
      send_request(make_packet(16'd28, OP_REQUEST, $urandom, 48'h0, 32'h0000_0001));
      send_request(make_packet(16'd27, OP_REPLY, 32'h0000_0000, 48'h1, 32'h0));
      send_request(make_packet(16'd0, OP_REPLY, 32'h0000_0000, 48'h1, 32'h0));
      send_request(make_packet(16'd27, OP_REQUEST, $urandom, 48'h1, 32'h0000_0000));
      send_request(make_packet(16'd28, OP_REPLY, 32'h0000_0000, 48'h0, $urandom));
      send_request(make_packet(16'hFFFF, OP_REPLY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                               32'hFFFF_FFFF));
      send_request(make_lookup(32'h0000_0000));
      send_request(make_lookup(32'hFFFF_FFFF));
      send_request(make_packet(16'd60, OP_REPLY, 32'h0000_0000, 48'h0123_4567_89AB, $urandom));
      send_request(make_lookup(32'h0000_0000));
      send_request(make_packet(16'd100, 16'h0000, 32'h0A00_0001, 48'h5, 32'h0000_0000));
      send_request(make_packet(16'd100, 16'h0003, 32'h0A00_0002, 48'h6, 32'h0000_0000));
      send_request(make_packet(16'd100, 16'hFFFF, 32'h0A00_0003, 48'h7, 32'h0000_0000));
      send_request(make_lookup(32'h0A00_0001));
      send_request(make_lookup(32'h0000_0001));
      drain();

      // random phases with changing idling and local address
      for (int p = 0; p < 3; p++) begin
         write_host_address(phase_ip[p]);
         sender_idle_pct   = (p == 0) ? 27 : (p == 1) ? 50 : 0;
         receiver_idle_pct = (p == 0) ? 50 : (p == 1) ? 27 : 0;
         send_request(make_packet(16'd28, OP_REQUEST, $urandom, 48'h0, phase_ip[p]));
         for (int n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
         drain();
      end

      $display("beats checked: %0d hits, %0d misses, %0d learned, %0d for us, %0d ignored",
               book.status_seen[ST_HIT], book.status_seen[ST_MISS],
               book.status_seen[ST_LEARNED], book.status_seen[ST_FOR_US],
               book.status_seen[ST_IGNORED]);
      $display("local address runs: zero, all ones, %h, zero again; cache overflowed to entry 0",
               phase_ip[1]);
      if (book.mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
